/* src/pkm_rle_pkg.sv */
// Types and constants shared by the run decoder files.
`timescale 1ns / 1ps
package pkm_rle_pkg;

    typedef enum logic [1:0] {
        CFG_BYTE_MARKER = 2'd0,
        CFG_WORD_MARKER = 2'd1,
        CFG_IMAGE_PIX   = 2'd2,
        CFG_DATA_BYTES  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_B_COLOUR = 3'd1,
        PH_B_COUNT  = 3'd2,
        PH_W_COLOUR = 3'd3,
        PH_W_HIGH   = 3'd4,
        PH_W_LOW    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0]  byte_run_marker;
        logic [7:0]  word_run_marker;
        logic [31:0] image_pixels;
        logic [31:0] data_bytes;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  run_colour;
        logic [7:0]  count_high;
        logic [31:0] pixels_written;
        logic [31:0] bytes_consumed;
    } t_state;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] run_length;
        logic [31:0] start_index;
        logic        image_done;
    } t_run;

endpackage

/* src/pkm_rle_in_if.sv */
// Input channel: one compressed byte per item.
`timescale 1ns / 1ps
interface pkm_rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

/* src/pkm_rle_out_if.sv */
// Output channel: one run descriptor per item.
`timescale 1ns / 1ps
interface pkm_rle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_value;
    logic [15:0] run_length;
    logic [31:0] start_index;
    logic        image_done;

    modport source (output valid, output pixel_value, output run_length,
                    output start_index, output image_done, input ready);
    modport sink   (input valid, input pixel_value, input run_length,
                    input start_index, input image_done, output ready);
endinterface

/* src/pkm_rle_run_decoder_unit.sv */
// Run decoder top level: config registers, parser state and result register.
//
//  channel  dir  handshake        payload
//  i_in     in   valid/ready      data_byte[7:0], restart
//  o_out    out  valid/ready      pixel_value[7:0], run_length[15:0],
//                                 start_index[31:0], image_done
//  cfg      in   i_cfg_we         i_cfg_idx[1:0], i_cfg_data[31:0]
//
// One byte per cycle: a byte is parsed in the cycle it is accepted and its run, if any,
// sits in the result register from the next cycle. The result register is the only
// stall point: a new byte is taken whenever it is empty or being drained. Reset
// (synchronous, active low) clears config, parser state and the result valid.
`timescale 1ns / 1ps
module pkm_rle_run_decoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  pkm_rle_pkg::t_cfg_idx i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    pkm_rle_in_if.sink           i_in,
    pkm_rle_out_if.source        o_out
);
    import pkm_rle_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_run   r_out;
    t_run   n_out;
    logic   r_out_valid;
    logic   n_emit;
    logic   in_ready;
    logic   accept;

    assign in_ready = !r_out_valid || o_out.ready;
    assign accept   = i_in.valid && in_ready;

    pkm_rle_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_data_byte (i_in.data_byte),
        .i_restart   (i_in.restart),
        .o_state     (n_state),
        .o_emit      (n_emit),
        .o_run       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BYTE_MARKER: r_cfg.byte_run_marker <= i_cfg_data[7:0];
                CFG_WORD_MARKER: r_cfg.word_run_marker <= i_cfg_data[7:0];
                CFG_IMAGE_PIX:   r_cfg.image_pixels    <= i_cfg_data;
                CFG_DATA_BYTES:  r_cfg.data_bytes      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_IDLE, default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_value = r_out.pixel_value;
    assign o_out.run_length  = r_out.run_length;
    assign o_out.start_index = r_out.start_index;
    assign o_out.image_done  = r_out.image_done;

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.run_length != '0)
        else $error("empty run in result register");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> r_out_valid && !o_out.ready)
        else $error("input stalled with room in result register");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_emit |=> r_out_valid && r_out.start_index == $past(n_out.start_index))
        else $error("run not loaded into result register");

    a_token_byte_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_in.restart && r_state.phase != PH_IDLE |=>
            r_state.bytes_consumed == $past(r_state.bytes_consumed) + 32'd1 ||
            $past(r_state.bytes_consumed) == '1)
        else $error("token byte not counted");

    a_no_run_mid_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (n_state.phase == PH_B_COLOUR || n_state.phase == PH_W_COLOUR ||
                   n_state.phase == PH_B_COUNT || n_state.phase == PH_W_HIGH ||
                   n_state.phase == PH_W_LOW) |-> !n_emit)
        else $error("run emitted before token completed");
endmodule

/* src/pkm_rle_step.sv */
// Parser step: next decoder state and optional run descriptor for one byte.
`timescale 1ns / 1ps
module pkm_rle_step (
    input  pkm_rle_pkg::t_cfg   i_cfg,
    input  pkm_rle_pkg::t_state i_state,
    input  logic [7:0]          i_data_byte,
    input  logic                i_restart,
    output pkm_rle_pkg::t_state o_state,
    output logic                o_emit,
    output pkm_rle_pkg::t_run   o_run
);
    import pkm_rle_pkg::*;

    t_state      st;
    logic [31:0] bc_inc;
    logic        budget_hit;
    logic        do_run;
    logic [15:0] count;
    logic [7:0]  colour;
    logic [31:0] remain;
    logic [31:0] sum;
    logic        clip;

    always_comb begin
        // restart clears everything before this byte is parsed
        st = i_restart ? t_state'{phase: PH_IDLE, default: '0} : i_state;
        bc_inc = (st.bytes_consumed != '1) ? st.bytes_consumed + 32'd1
                                           : st.bytes_consumed;
        budget_hit = (st.pixels_written >= i_cfg.image_pixels) ||
                     (st.bytes_consumed >= i_cfg.data_bytes);

        o_state = st;
        do_run  = 1'b0;
        count   = '0;
        colour  = st.run_colour;

        unique case (st.phase)
            PH_B_COLOUR: begin
                o_state.run_colour     = i_data_byte;
                o_state.bytes_consumed = bc_inc;
                o_state.phase          = PH_B_COUNT;
            end
            PH_B_COUNT: begin
                o_state.bytes_consumed = bc_inc;
                o_state.phase          = PH_IDLE;
                do_run                 = 1'b1;
                count                  = {8'h00, i_data_byte};
            end
            PH_W_COLOUR: begin
                o_state.run_colour     = i_data_byte;
                o_state.bytes_consumed = bc_inc;
                o_state.phase          = PH_W_HIGH;
            end
            PH_W_HIGH: begin
                o_state.count_high     = i_data_byte;
                o_state.bytes_consumed = bc_inc;
                o_state.phase          = PH_W_LOW;
            end
            PH_W_LOW: begin
                o_state.bytes_consumed = bc_inc;
                o_state.phase          = PH_IDLE;
                do_run                 = 1'b1;
                count                  = {st.count_high, i_data_byte};
            end
            default: begin
                o_state.phase = PH_IDLE;
                // drop the byte once either budget is used up
                if (!budget_hit) begin
                    o_state.bytes_consumed = bc_inc;
                    if (i_data_byte == i_cfg.byte_run_marker) begin
                        o_state.phase = PH_B_COLOUR;
                    end else if (i_data_byte == i_cfg.word_run_marker) begin
                        o_state.phase = PH_W_COLOUR;
                    end else begin
                        do_run = 1'b1;
                        count  = 16'd1;
                        colour = i_data_byte;
                    end
                end
            end
        endcase

        // clip to the pixels left; the clipped run ends exactly at image_pixels
        remain = i_cfg.image_pixels - st.pixels_written;
        clip   = ({16'h0000, count} >= remain);
        sum    = st.pixels_written + {16'h0000, count};
        o_emit = do_run && (count != '0) && (remain != '0);

        o_run.pixel_value = colour;
        o_run.run_length  = clip ? remain[15:0] : count;
        o_run.start_index = st.pixels_written;
        o_run.image_done  = clip || (sum >= i_cfg.image_pixels) ||
                            (o_state.bytes_consumed >= i_cfg.data_bytes);

        if (o_emit) begin
            o_state.pixels_written = clip ? i_cfg.image_pixels : sum;
        end
    end
endmodule

/* test/tb_pkm_rle_run_decoder_unit.sv */
// Self-checking testbench for pkm_rle_run_decoder_unit: byte streams in, predicted runs checked.
`timescale 1ns / 1ps
module tb_pkm_rle_run_decoder_unit;
    import pkm_rle_pkg::*;

    // Tracks parser state and budgets, and holds the runs the block still owes.
    class run_scoreboard;
        t_cfg        cfg;
        t_phase      phase;
        logic [7:0]  colour;
        logic [7:0]  count_hi;
        logic [31:0] pix_done;
        logic [31:0] bytes_used;
        t_run        expected_runs[$];
        int          errors;
        int          runs_checked;
        int          live_bytes;
        int          restarts;

        function new();
            cfg = '0;
            phase = PH_IDLE;
            colour = '0;
            count_hi = '0;
            pix_done = '0;
            bytes_used = '0;
            errors = 0;
            runs_checked = 0;
            live_bytes = 0;
            restarts = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_BYTE_MARKER: cfg.byte_run_marker = val[7:0];
                CFG_WORD_MARKER: cfg.word_run_marker = val[7:0];
                CFG_IMAGE_PIX:   cfg.image_pixels = val;
                default:         cfg.data_bytes = val;
            endcase
        endfunction

        function bit budget_reached();
            return (pix_done >= cfg.image_pixels) || (bytes_used >= cfg.data_bytes);
        endfunction

        function void count_byte();
            if (bytes_used != 32'hFFFF_FFFF) bytes_used++;
        endfunction

        // Clip the run to the pixels left and queue its descriptor.
        function void add_run(logic [7:0] c, logic [31:0] count);
            logic [31:0] remain;
            logic [31:0] len;
            t_run        r;
            if (count == 0) return;
            remain = cfg.image_pixels - pix_done;
            len = (count < remain) ? count : remain;
            if (len == 0) return;
            r.pixel_value = c;
            r.run_length = len[15:0];
            r.start_index = pix_done;
            pix_done += len;
            r.image_done = budget_reached();
            expected_runs.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic rs);
            if (rs) begin
                phase = PH_IDLE;
                colour = '0;
                count_hi = '0;
                pix_done = '0;
                bytes_used = '0;
                restarts++;
            end
            case (phase)
                PH_B_COLOUR: begin
                    colour = b;
                    count_byte();
                    phase = PH_B_COUNT;
                    live_bytes++;
                end
                PH_B_COUNT: begin
                    count_byte();
                    phase = PH_IDLE;
                    live_bytes++;
                    add_run(colour, {24'd0, b});
                end
                PH_W_COLOUR: begin
                    colour = b;
                    count_byte();
                    phase = PH_W_HIGH;
                    live_bytes++;
                end
                PH_W_HIGH: begin
                    count_hi = b;
                    count_byte();
                    phase = PH_W_LOW;
                    live_bytes++;
                end
                PH_W_LOW: begin
                    count_byte();
                    phase = PH_IDLE;
                    live_bytes++;
                    add_run(colour, {16'd0, count_hi, b});
                end
                default: begin
                    phase = PH_IDLE;
                    // drop the byte once either budget is used up
                    if (!budget_reached()) begin
                        count_byte();
                        live_bytes++;
                        if (b == cfg.byte_run_marker) phase = PH_B_COLOUR;
                        else if (b == cfg.word_run_marker) phase = PH_W_COLOUR;
                        else add_run(b, 32'd1);
                    end
                end
            endcase
        endfunction

        function void check_run(t_run act);
            t_run exp_run;
            if (expected_runs.size() == 0) begin
                $error("unexpected run: pixel_value %0d run_length %0d start_index %0d",
                       act.pixel_value, act.run_length, act.start_index);
                errors++;
                return;
            end
            exp_run = expected_runs.pop_front();
            runs_checked++;
            if (act.pixel_value !== exp_run.pixel_value) begin
                $error("pixel_value: expected %0d, got %0d", exp_run.pixel_value, act.pixel_value);
                errors++;
            end
            if (act.run_length !== exp_run.run_length) begin
                $error("run_length: expected %0d, got %0d", exp_run.run_length, act.run_length);
                errors++;
            end
            if (act.start_index !== exp_run.start_index) begin
                $error("start_index: expected %0d, got %0d", exp_run.start_index, act.start_index);
                errors++;
            end
            if (act.image_done !== exp_run.image_done) begin
                $error("image_done: expected %0d, got %0d", exp_run.image_done, act.image_done);
                errors++;
            end
        endfunction

        function void flush_leftovers();
            while (expected_runs.size() > 0) begin
                $error("missing run: pixel_value %0d run_length %0d start_index %0d",
                       expected_runs[0].pixel_value, expected_runs[0].run_length,
                       expected_runs[0].start_index);
                errors++;
                void'(expected_runs.pop_front());
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_idx = CFG_BYTE_MARKER;
    logic [31:0] i_cfg_data = '0;

    pkm_rle_in_if  in_ch ();
    pkm_rle_out_if out_ch ();

    run_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int bytes_sent = 0;
    int cfg_settings = 0;

    pkm_rle_run_decoder_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_pkm_rle_run_decoder_unit failed");
        $finish;
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 36);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !idle_now();
            end
        end
    end

    always @(posedge i_clk) begin
        t_run act;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            act.pixel_value = out_ch.pixel_value;
            act.run_length = out_ch.run_length;
            act.start_index = out_ch.start_index;
            act.image_done = out_ch.image_done;
            sb.check_run(act);
        end
    end

    // Entered and left at a falling edge.
    task automatic send_byte(logic [7:0] b, logic rs);
        while (idle_now()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.restart <= rs;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_byte(b, rs);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [7:0] bm, logic [7:0] wm, logic [31:0] pix,
                              logic [31:0] nbytes);
        t_cfg_idx    idx;
        logic [31:0] val;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_BYTE_MARKER: val = {24'($urandom), bm};
                CFG_WORD_MARKER: val = {24'($urandom), wm};
                CFG_IMAGE_PIX:   val = pix;
                default:         val = nbytes;
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx;
            i_cfg_data <= val;
            sb.write_reg(idx, val);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    // Wait out all owed runs, then let the registered result settle before checking for leftovers.
    task automatic drain_block();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (sb.expected_runs.size() > 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
        sb.flush_leftovers();
    endtask

    // Mostly well-formed tokens with random content, some noise; restart when stuck.
    task automatic random_phase(int target);
        int    start_live;
        int    start_sent;
        int    kind;
        bit    rs;
        logic [7:0] hi;
        start_live = sb.live_bytes;
        start_sent = bytes_sent;
        while (sb.live_bytes - start_live < target && bytes_sent - start_sent < 4 * target) begin
            if (sb.phase == PH_IDLE && sb.budget_reached()) rs = ($urandom_range(1) == 1);
            else rs = ($urandom_range(49) == 0);
            kind = $urandom_range(99);
            if (kind < 40) begin
                send_byte(8'($urandom_range(255)), rs);
            end else if (kind < 65) begin
                send_byte(sb.cfg.byte_run_marker, rs);
                send_byte(8'($urandom_range(255)), 1'b0);
                send_byte(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)), 1'b0);
            end else if (kind < 85) begin
                kind = $urandom_range(9);
                hi = (kind < 7) ? 8'd0 : (kind < 9) ? 8'($urandom_range(1, 3))
                                                    : 8'($urandom_range(255));
                send_byte(sb.cfg.word_run_marker, rs);
                send_byte(8'($urandom_range(255)), 1'b0);
                send_byte(hi, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b0);
            end else begin
                send_byte(8'($urandom_range(255)), rs);
                repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
            end
        end
        drain_block();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.restart = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // literals, both run forms, zero counts, restart inside a token, clipping
        set_config(8'hF0, 8'h0F, 32'd300, 32'd1000);
        send_byte(8'h00, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h21, 1'b1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hF0, 1'b1);
        send_byte(8'h99, 1'b0);
        send_byte(8'h03, 1'b0);
        drain_block();

        // equal markers; a token started under the byte budget runs past it
        set_config(8'h80, 8'h80, 32'hFFFF_FFFF, 32'd4);
        send_byte(8'h80, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h33, 1'b0);
        drain_block();

        // empty image: everything is dropped
        set_config(8'h00, 8'hFF, 32'd0, 32'hFFFF_FFFF);
        send_byte(8'h42, 1'b1);
        drain_block();

        set_config(8'($urandom), 8'($urandom), $urandom_range(200, 3000), $urandom_range(100, 800));
        random_phase(300);
        set_config(8'($urandom), 8'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        begin
            logic [7:0] same;
            same = 8'($urandom);
            set_config(same, same, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end
        random_phase(250);
        set_config(8'h00, 8'hFF, $urandom_range(1, 40), 32'hFFFF_FFFF);
        random_phase(300);
        set_config(8'hFF, 8'h00, 32'hFFFF_FFFF, $urandom_range(1, 20));
        random_phase(300);

        // no idling; the result side holds off long enough to back up the input
        calm = 1'b1;
        hold_req = 1'b1;
        set_config(8'($urandom), 8'($urandom), $urandom_range(500, 5000), $urandom_range(200, 2000));
        random_phase(350);
        calm = 1'b0;

        repeat (10) @(negedge i_clk);
        $display("Sent %0d bytes (%0d decoded, %0d restarts) over %0d register settings",
                 bytes_sent, sb.live_bytes, sb.restarts, cfg_settings);
        $display("Checked %0d runs, %0d mismatches", sb.runs_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_pkm_rle_run_decoder_unit passed");
        end else begin
            $display("tb_pkm_rle_run_decoder_unit failed");
        end
        $finish;
    end
endmodule

/* pkm_rle_run_decoder_unit.f */
src/pkm_rle_pkg.sv
src/pkm_rle_in_if.sv
src/pkm_rle_out_if.sv
src/pkm_rle_step.sv
src/pkm_rle_run_decoder_unit.sv
test/tb_pkm_rle_run_decoder_unit.sv
